// ===== rtl/lgs_pkg.sv =====
// shared types and constants for the life generation step core
package lgs_pkg;

   localparam int MAX_COLS  = 64;
   localparam int MAX_ROWS  = 64;
   localparam int ROW_W     = 64;
   localparam int ROW_LIM   = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int CSR_W     = 7;
   localparam int RNUM_W    = 6;
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = 2;
   localparam int Q_CW      = 3;
   localparam int RSP_TD_W  = 72;

   localparam logic CSR_ROWS_IDX = 1'b0;
   localparam logic CSR_COLS_IDX = 1'b1;

   // masked cell bits that a cell hands to both neighbors
   typedef struct packed {
      logic up;
      logic mid;
      logic cur;
   } lgs_nbr_type;

   // one queued response
   typedef struct packed {
      logic              final_row;
      logic [RNUM_W-1:0] row_number;
      logic [ROW_W-1:0]  next_cells;
   } lgs_rsp_type;

endpackage

// ===== rtl/lgs_cell.sv =====
// one grid column: keeps two row bits and applies the b3/s23 rule
module lgs_cell import lgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic        clear,
   input  logic        mask,
   input  logic        cur_bit,
   input  lgs_nbr_type left,
   input  lgs_nbr_type right,
   output lgs_nbr_type own,
   output logic        next_upper,
   output logic        next_final
);

   logic       up_ff, up_in;
   logic       mid_ff, mid_in;
   logic [3:0] cnt_a, cnt_b;

   always_comb begin
      own.up  = up_ff & mask;
      own.mid = mid_ff & mask;
      own.cur = cur_bit & mask;
   end

   // row above the current one, centered on middle, and the last row with nothing below it
   always_comb begin
      cnt_a = 4'(left.up) + 4'(own.up) + 4'(right.up)
            + 4'(left.mid) + 4'(right.mid)
            + 4'(left.cur) + 4'(own.cur) + 4'(right.cur);
      cnt_b = 4'(left.mid) + 4'(own.mid) + 4'(right.mid)
            + 4'(left.cur) + 4'(right.cur);
      next_upper = mask & ((cnt_a == 4'd3) || ((cnt_a == 4'd2) && own.mid));
      next_final = mask & ((cnt_b == 4'd3) || ((cnt_b == 4'd2) && own.cur));
   end

   always_comb begin
      up_in  = up_ff;
      mid_in = mid_ff;
      if (load) begin
         if (clear) begin
            up_in  = 1'b0;
            mid_in = 1'b0;
         end else begin
            up_in  = own.mid;
            mid_in = own.cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff  <= 1'b0;
         mid_ff <= 1'b0;
      end else begin
         up_ff  <= up_in;
         mid_ff <= mid_in;
      end
   end

endmodule

// ===== rtl/lgs_rsp_queue.sv =====
// small response queue taking up to two entries and giving one per cycle while popped
module lgs_rsp_queue import lgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_a,
   input  lgs_rsp_type data_a,
   input  logic        push_b,
   input  lgs_rsp_type data_b,
   input  logic        pop,
   output lgs_rsp_type out_data,
   output logic        out_valid,
   output logic        room_for_two
);

   lgs_rsp_type          q_ff [Q_DEPTH];
   logic [Q_AW-1:0]      wr_ff, wr_in;
   logic [Q_AW-1:0]      rd_ff, rd_in;
   logic [Q_CW-1:0]      cnt_ff, cnt_in;
   logic                 do_pop;

   assign out_valid    = (cnt_ff != '0);
   assign out_data     = q_ff[rd_ff];
   assign room_for_two = (cnt_ff <= Q_CW'(Q_DEPTH - 2));
   assign do_pop       = pop & out_valid;

   always_comb begin
      wr_in  = wr_ff + Q_AW'(push_a) + Q_AW'(push_b);
      rd_in  = rd_ff + Q_AW'(do_pop);
      cnt_in = cnt_ff + Q_CW'(push_a) + Q_CW'(push_b) - Q_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // first entry goes to the write pointer, a second one right behind it
   always_ff @(posedge clock) begin
      if (push_a) begin
         q_ff[wr_ff] <= data_a;
         if (push_b) begin
            q_ff[wr_ff + Q_AW'(1)] <= data_b;
         end
      end else if (push_b) begin
         q_ff[wr_ff] <= data_b;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CW'(Q_DEPTH))
      else $error("response queue count beyond depth");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push_a && push_b && !do_pop) |=> cnt_ff == $past(cnt_ff) + Q_CW'(2))
      else $error("double push not counted");

endmodule

// ===== rtl/life_generation_step_core.sv =====
// top level: streaming life generation step over a row of column cells
//
//  channel | ports                              | carries
//  --------+------------------------------------+---------------------------------
//  request | req_tvalid req_tready req_tdata    | one grid row, bit c = column c
//  response| rsp_tvalid rsp_tready rsp_tdata   | next-generation row and row index,
//          | rsp_tlast                          | tlast marks the last row
//  csr     | csr_valid csr_ready csr_index      | rows_in_use (0), cols_in_use (1)
//          | csr_data                           |
//
// one request per cycle while the queue has room; each column cell applies the rule in the same cycle
// and the results go into a four-entry response queue
// the last row of a generation yields two responses, unless it is also the first row
// req_tready is high while the queue has room for two entries
// a stalled response side fills the queue and then holds off requests
// synchronous active-high reset clears the row bits, the row count and the queue
module life_generation_step_core import lgs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request: [63:0] row_cells
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ROW_W-1:0]    req_tdata,
   // response: [63:0] next_cells, [69:64] row_number, [71:70] zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_TD_W-1:0] rsp_tdata,
   output logic                rsp_tlast,
   // csr writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   logic [CSR_W-1:0]  rows_cfg_ff, rows_cfg_in;
   logic [CSR_W-1:0]  cols_cfg_ff, cols_cfg_in;
   logic [RNUM_W-1:0] rows_seen_ff, rows_seen_in;

   logic [CSR_W-1:0]  rows_eff, cols_eff;
   logic [ROW_W-1:0]  col_mask;
   logic              req_acc;
   logic              last_row;
   logic              have_upper;

   lgs_nbr_type       nbr [ROW_W];
   logic [ROW_W-1:0]  next_upper, next_final;
   lgs_rsp_type       rsp_a, rsp_b, rsp_head;

   assign csr_ready = 1'b1;
   assign req_acc   = req_tvalid & req_tready;

   // csr register writes
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_IDX: rows_cfg_in = csr_data;
            CSR_COLS_IDX: cols_cfg_in = csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, too large acts as the limit
   always_comb begin
      rows_eff = rows_cfg_ff;
      if (rows_eff == '0) rows_eff = CSR_W'(1);
      if (rows_eff > CSR_W'(ROW_LIM)) rows_eff = CSR_W'(ROW_LIM);
      cols_eff = cols_cfg_ff;
      if (cols_eff == '0) cols_eff = CSR_W'(1);
      if (cols_eff > CSR_W'(MAX_COLS)) cols_eff = CSR_W'(MAX_COLS);
   end

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         col_mask[i] = (CSR_W'(i) < cols_eff);
      end
   end

   // row count also covers a row count shrunk below rows already seen
   assign have_upper = (rows_seen_ff != '0);
   assign last_row   = ({1'b0, rows_seen_ff} + CSR_W'(1)) >= rows_eff;

   always_comb begin
      rows_seen_in = rows_seen_ff;
      if (req_acc) begin
         if (last_row) rows_seen_in = '0;
         else          rows_seen_in = rows_seen_ff + RNUM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= CSR_W'(64);
         cols_cfg_ff  <= CSR_W'(64);
         rows_seen_ff <= '0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

   // one cell per column, outside columns read as dead
   for (genvar g = 0; g < ROW_W; g++) begin : g_col
      lgs_nbr_type left_n, right_n;
      if (g == 0) begin : g_l0
         assign left_n = '0;
      end else begin : g_ln
         assign left_n = nbr[g-1];
      end
      if (g == ROW_W - 1) begin : g_r0
         assign right_n = '0;
      end else begin : g_rn
         assign right_n = nbr[g+1];
      end
      lgs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (req_acc),
         .clear      (last_row),
         .mask       (col_mask[g]),
         .cur_bit    (req_tdata[g]),
         .left       (left_n),
         .right      (right_n),
         .own        (nbr[g]),
         .next_upper (next_upper[g]),
         .next_final (next_final[g])
      );
   end

   // first response: row above, second: the last row itself
   always_comb begin
      rsp_a.final_row  = 1'b0;
      rsp_a.row_number = rows_seen_ff - RNUM_W'(1);
      rsp_a.next_cells = next_upper;
      rsp_b.final_row  = 1'b1;
      rsp_b.row_number = rows_seen_ff;
      rsp_b.next_cells = next_final;
   end

   lgs_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_a       (req_acc & have_upper),
      .data_a       (rsp_a),
      .push_b       (req_acc & last_row),
      .data_b       (rsp_b),
      .pop          (rsp_tready),
      .out_data     (rsp_head),
      .out_valid    (rsp_tvalid),
      .room_for_two (req_tready)
   );

   assign rsp_tdata = {(RSP_TD_W - ROW_W - RNUM_W)'(0), rsp_head.row_number,
                       rsp_head.next_cells};
   assign rsp_tlast = rsp_head.final_row;

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_row) |=> rows_seen_ff == '0)
      else $error("row count not cleared after last row");

   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !last_row) |=> rows_seen_ff == $past(rows_seen_ff) + RNUM_W'(1))
      else $error("row count did not advance");

endmodule

// ===== bench/life_generation_step_core_tb.sv =====
// testbench for life_generation_step_core: directed grids and random generations, scoreboarded
`timescale 1ns / 1ps

module life_generation_step_core_tb;
   import lgs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ROWS = 225;   // per pacing phase, four phases

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ROW_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_TD_W-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_ROWS_IDX;
   logic [CSR_W-1:0]    csr_data = '0;

   // pacing knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // predicted generation state, mirrors the core
   logic [CSR_W-1:0] rows_cfg = CSR_W'(64);
   logic [CSR_W-1:0] cols_cfg = CSR_W'(64);
   logic [ROW_W-1:0] upper_cells = '0;
   logic [ROW_W-1:0] middle_cells = '0;
   logic [6:0]       rows_received = '0;

   lgs_rsp_type pending_rows[$];
   lgs_rsp_type expected_row;

   int fail_count     = 0;
   int rows_sent      = 0;
   int results_seen   = 0;
   int setting_writes = 0;
   int cycle_count    = 0;

   life_generation_step_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side back-pressure, changes on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // zero acts as one column, anything past the row width acts as full width
   function automatic logic [ROW_W-1:0] column_mask(input logic [CSR_W-1:0] setting);
      int n;
      n = int'(setting);
      if (n < 1) n = 1;
      if (n > MAX_COLS) n = MAX_COLS;
      if (n >= ROW_W) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic int generation_rows(input logic [CSR_W-1:0] setting);
      int n;
      n = int'(setting);
      if (n < 1) n = 1;
      if (n > ROW_LIM) n = ROW_LIM;
      return n;
   endfunction

   // B3/S23 over one row, cells off the row edge are dead
   function automatic logic [ROW_W-1:0] life_rule_row(input logic [ROW_W-1:0] above,
                                                      input logic [ROW_W-1:0] center,
                                                      input logic [ROW_W-1:0] below,
                                                      input logic [ROW_W-1:0] mask);
      logic [ROW_W-1:0] result;
      int live;
      result = '0;
      for (int c = 0; c < ROW_W; c++) begin
         live = 0;
         for (int d = -1; d <= 1; d++) begin
            if (c + d >= 0 && c + d < ROW_W) begin
               live += int'(above[c+d]) + int'(below[c+d]);
               if (d != 0) live += int'(center[c+d]);
            end
         end
         if (live == 3 || (live == 2 && center[c])) result[c] = 1'b1;
      end
      return result & mask;
   endfunction

   // one accepted row: emit the finished rows and shift the window
   function automatic void advance_generation(input logic [ROW_W-1:0] cells);
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] cur;
      logic [ROW_W-1:0] up;
      logic [ROW_W-1:0] mid;
      int rows;
      int seen;
      lgs_rsp_type item;
      mask = column_mask(cols_cfg);
      rows = generation_rows(rows_cfg);
      cur  = cells & mask;
      seen = int'(rows_received);
      // window may still hold bits from a wider column setting
      up   = upper_cells & mask;
      mid  = middle_cells & mask;
      if (seen >= 1) begin
         item.next_cells = life_rule_row(up, mid, cur, mask);
         item.row_number = RNUM_W'(seen - 1);
         item.final_row  = 1'b0;
         pending_rows.push_back(item);
      end
      // last row, also reached when the row count shrank under us
      if (seen + 1 >= rows) begin
         item.next_cells = life_rule_row((seen >= 1) ? mid : '0, cur, '0, mask);
         item.row_number = RNUM_W'(seen);
         item.final_row  = 1'b1;
         pending_rows.push_back(item);
         upper_cells   = '0;
         middle_cells  = '0;
         rows_received = '0;
      end else begin
         upper_cells   = mid;
         middle_cells  = cur;
         rows_received = 7'(seen + 1);
      end
   endfunction

   // ---------------------------------------------------------------
   // monitor: settings, requests and responses in one fixed order
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS_IDX) rows_cfg = csr_data;
            else cols_cfg = csr_data;
         end
         if (req_tvalid && req_tready) advance_generation(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_rows.size() == 0) begin
               $error("response with nothing outstanding: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               expected_row = pending_rows.pop_front();
               if (rsp_tdata[ROW_W-1:0] !== expected_row.next_cells) begin
                  $error("next_cells expected %h actual %h",
                         expected_row.next_cells, rsp_tdata[ROW_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[ROW_W+RNUM_W-1:ROW_W] !== expected_row.row_number) begin
                  $error("row_number expected %0d actual %0d",
                         expected_row.row_number, rsp_tdata[ROW_W+RNUM_W-1:ROW_W]);
                  fail_count++;
               end
               if (rsp_tlast !== expected_row.final_row) begin
                  $error("final_row expected %b actual %b",
                         expected_row.final_row, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tdata[RSP_TD_W-1:ROW_W+RNUM_W] !== '0) begin
                  $error("tdata padding expected 0 actual %h",
                         rsp_tdata[RSP_TD_W-1:ROW_W+RNUM_W]);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers, each entered and left on a falling edge
   // ---------------------------------------------------------------

   // one row request; valid stays up into the next call unless the sender idles
   task automatic send_row(input logic [ROW_W-1:0] cells);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cells;
      do @(posedge clock); while (!req_tready);
      rows_sent++;
      @(negedge clock);
   endtask

   // hold off requests until every predicted row has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_rows.size() != 0);
   endtask

   // settings only change with the core drained
   task automatic write_setting(input logic index, input logic [CSR_W-1:0] value);
      wait_for_results();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      setting_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ROW_W-1:0] random_row();
      logic [ROW_W-1:0] a;
      logic [ROW_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return a & b & {$urandom, $urandom};   // sparse
         3: return a | b;                          // dense
         default: return a;
      endcase
   endfunction

   // small and any in-range counts, plus zero, the top and out-of-range values
   function automatic logic [CSR_W-1:0] random_setting();
      case ($urandom_range(9))
         0: return '0;
         1: return CSR_W'(1);
         2: return CSR_W'(64);
         3: return CSR_W'($urandom_range(65, 127));
         4, 5: return CSR_W'($urandom_range(2, 8));
         default: return CSR_W'($urandom_range(1, 64));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // zero settings act as one, then single-row generations at full width
   task automatic test_tiny_grids();
      write_setting(CSR_ROWS_IDX, '0);
      write_setting(CSR_COLS_IDX, '0);
      send_row('1);
      send_row(64'h1);
      write_setting(CSR_ROWS_IDX, CSR_W'(1));
      write_setting(CSR_COLS_IDX, CSR_W'(64));
      send_row('1);                      // ends die, inner cells survive on two
      send_row(64'h8000_0000_0000_0001);
      send_row(64'h5555_5555_5555_5555);
   endtask

   // blinker flips, a full block thins out, column 63 at the edge
   task automatic test_oscillator_and_edges();
      write_setting(CSR_ROWS_IDX, CSR_W'(3));
      write_setting(CSR_COLS_IDX, CSR_W'(127));   // acts as full width
      send_row(64'h400);
      send_row(64'h400);
      send_row(64'h400);
      write_setting(CSR_ROWS_IDX, CSR_W'(4));
      send_row('1);
      send_row('1);
      send_row(64'hC000_0000_0000_0003);
      send_row(64'h8000_0000_0000_0000);
   endtask

   // settings changed with a generation half done
   task automatic test_setting_change_mid_generation();
      write_setting(CSR_ROWS_IDX, CSR_W'(65));    // acts as the row limit
      write_setting(CSR_COLS_IDX, CSR_W'(8));
      repeat (4) send_row({$urandom, $urandom});
      // four rows seen, two allowed: next row closes the generation
      write_setting(CSR_ROWS_IDX, CSR_W'(2));
      send_row('1);
      write_setting(CSR_ROWS_IDX, CSR_W'(6));
      write_setting(CSR_COLS_IDX, CSR_W'(64));
      repeat (3) send_row('1);
      // narrower columns, the window still holds wide rows
      write_setting(CSR_COLS_IDX, CSR_W'(4));
      repeat (3) send_row('1);
   endtask

   // random generations, some cut short by a settings change
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int sent;
      int remaining;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < RANDOM_ROWS) begin
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
               0: write_setting(CSR_ROWS_IDX, random_setting());
               1: write_setting(CSR_COLS_IDX, random_setting());
               default: begin
                  write_setting(CSR_ROWS_IDX, random_setting());
                  write_setting(CSR_COLS_IDX, random_setting());
               end
            endcase
         end
         remaining = generation_rows(rows_cfg) - int'(rows_received);
         if (remaining < 1) remaining = 1;
         if ($urandom_range(4) == 0) remaining = $urandom_range(1, remaining);
         repeat (remaining) send_row(random_row());
         sent += remaining;
         // sender holds off until the core has drained
         if ($urandom_range(7) == 0) wait_for_results();
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_tiny_grids();
      test_oscillator_and_edges();
      test_setting_change_mid_generation();
      test_random_traffic(0, 0);
      test_random_traffic(61, 0);
      test_random_traffic(0, 61);
      test_random_traffic(35, 35);

      wait_for_results();
      repeat (16) @(posedge clock);

      $display("%0d row requests sent, %0d next-generation rows checked, %0d setting writes",
               rows_sent, results_seen, setting_writes);
      $display("pacing: back to back, sender idling, receiver stalling, and both together");
      if (fail_count == 0 && pending_rows.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== life_generation_step_core.f =====
rtl/lgs_pkg.sv
rtl/lgs_cell.sv
rtl/lgs_rsp_queue.sv
rtl/life_generation_step_core.sv
bench/life_generation_step_core_tb.sv
